/* src/pppc_pkg.sv */
package pppc_pkg;

    // Time base and angle constants
    localparam int TIME_FRAC_BITS = 20;
    localparam int PI_Q13         = 25736;
    localparam int TWO_PI_Q13     = 51472;

    // Datapath widths
    localparam int ACC_W   = 48;
    localparam int DIV_W   = 34 + TIME_FRAC_BITS;
    localparam int DIV_CW  = $clog2(DIV_W + 1);
    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fraction shifts back to Q16.16
    localparam int FS_POS  = 8;
    localparam int FS_HEAD = 5;

    // Axis numbers
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_H = 2'd2;

    // Register reset values
    localparam logic [47:0] GAINS_XY_RST   = 48'h1400_0000_001A;
    localparam logic [47:0] GAINS_HEAD_RST = 48'h0F00_0000_0000;
    localparam logic [30:0] STOP_DIST_RST  = 31'd328;
    localparam logic [14:0] STOP_ANG_RST   = 15'd41;

    typedef enum logic [2:0] {
        CFG_GAINS_X,
        CFG_GAINS_Y,
        CFG_GAINS_HEADING,
        CFG_STOP_DISTANCE,
        CFG_STOP_ANGLE
    } cfg_idx_t;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        MA_ABS_EX,
        MA_ABS_EY,
        MA_SD,
        MA_ERR,
        MA_AREG,
        MA_DREG
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_LO,
        MB_HI,
        MB_DT,
        MB_GP,
        MB_GI,
        MB_GD
    } mul_b_t;

    // Accumulate / update operations on the product register
    typedef enum logic [3:0] {
        AO_NONE,
        AO_SQ_SET,
        AO_SQ_ADD,
        AO_SQ_ADD_SH,
        AO_LIM_SET,
        AO_LIM_ADD_SH,
        AO_DECIDE,
        AO_ACC_UPD,
        AO_SUM_P,
        AO_SUM_I,
        AO_D_LOAD,
        AO_SUM_D,
        AO_COMMIT
    } acc_op_t;

    typedef struct packed {
        logic       load;
        logic [1:0] axis;
        mul_a_t     a_sel;
        mul_b_t     b_sel;
        acc_op_t    op;
        logic       div_start;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_window;
        logic div_done;
    } dp_status_t;

endpackage

/* src/pppc_if.sv */
interface pppc_pose_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic        [19:0] elapsed_time;

    modport source (output valid, command, pose_x, pose_y, pose_heading, elapsed_time,
                    input ready);
    modport sink (input valid, command, pose_x, pose_y, pose_heading, elapsed_time,
                  output ready);
endinterface

interface pppc_drive_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_turn;
    logic               stopped;

    modport source (output valid, vel_x, vel_y, vel_turn, stopped, input ready);
    modport sink (input valid, vel_x, vel_y, vel_turn, stopped, output ready);
endinterface

/* src/planar_pose_pid_controller.sv */
// Three-axis pose PID controller. A target request (command 0) is taken while idle and
// gives no result; a measurement with zero elapsed time likewise. A measurement that
// lands inside the stop window ends after the stop test; otherwise each axis'
// derivative goes through a shared restoring divider that makes one quotient bit per
// cycle, and all products come from one 49x21 multiplier. One measurement is in work
// at a time; the next request is taken while the previous result still waits in the
// output register.
module planar_pose_pid_controller
    import pppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    pppc_pose_if.sink    pose,
    pppc_drive_if.source drive
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pppc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pose.valid),
        .in_command (pose.command),
        .in_dt_zero (pose.elapsed_time == '0),
        .in_ready   (pose.ready),
        .out_valid  (drive.valid),
        .out_ready  (drive.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pppc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (pose.command),
        .pose_x       (pose.pose_x),
        .pose_y       (pose.pose_y),
        .pose_heading (pose.pose_heading),
        .elapsed_time (pose.elapsed_time),
        .cmd          (cmd),
        .status       (status),
        .vel_x        (drive.vel_x),
        .vel_y        (drive.vel_y),
        .vel_turn     (drive.vel_turn),
        .stopped      (drive.stopped)
    );

endmodule

/* src/pppc_div.sv */
module pppc_div
    import pppc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [19:0]       divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    logic [19:0]       rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [19:0]       dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic [20:0]       rem_sh;
    logic [20:0]       rem_sub;
    logic              take;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign take    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CW'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub[19:0] : rem_sh[19:0];
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* src/pppc_datapath.sv */
module pppc_datapath
    import pppc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               command,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [15:0] pose_heading,
    input  logic [19:0]        elapsed_time,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_turn,
    output logic               stopped
);

    localparam logic signed [16:0] PI17     = 17'(PI_Q13);
    localparam logic signed [16:0] TWO_PI17 = 17'(TWO_PI_Q13);

    // Configuration
    logic [47:0]        gains_reg [3];
    logic [30:0]        stop_dist_reg;
    logic [14:0]        stop_ang_reg;

    // Controller state
    logic signed [31:0] target_x_reg;
    logic signed [31:0] target_y_reg;
    logic signed [15:0] target_h_reg;
    logic signed [32:0] last_reg [3];
    logic signed [47:0] accum_reg [3];

    // Working registers
    logic signed [32:0] err_reg [3];
    logic [30:0]        abs_reg [2];
    logic               pos_ok_reg;
    logic [14:0]        ah_reg;
    logic [19:0]        dt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        lim_reg;
    logic signed [63:0] sum_reg;
    logic signed [47:0] a_reg;
    logic signed [47:0] d_reg;
    logic               d_neg_reg;
    logic               inside_reg;
    logic signed [31:0] res_reg [3];
    logic signed [31:0] vel_x_reg;
    logic signed [31:0] vel_y_reg;
    logic signed [31:0] vel_turn_reg;
    logic               stopped_reg;

    // Error formation on load
    logic signed [32:0] ex_new;
    logic signed [32:0] ey_new;
    logic signed [32:0] abs_ex;
    logic signed [32:0] abs_ey;
    logic signed [16:0] eh_raw;
    logic signed [16:0] eh_wrap;
    logic signed [16:0] ah_new;

    assign ex_new = {target_x_reg[31], target_x_reg} - {pose_x[31], pose_x};
    assign ey_new = {target_y_reg[31], target_y_reg} - {pose_y[31], pose_y};
    assign abs_ex = ex_new[32] ? -ex_new : ex_new;
    assign abs_ey = ey_new[32] ? -ey_new : ey_new;
    assign eh_raw = {target_h_reg[15], target_h_reg} - {pose_heading[15], pose_heading};

    // Heading wrap: one correction is always enough for 16-bit operands
    always_comb
    begin
        if (eh_raw > PI17)
            eh_wrap = eh_raw - TWO_PI17;
        else if (eh_raw < -PI17)
            eh_wrap = eh_raw + TWO_PI17;
        else
            eh_wrap = eh_raw;
    end

    assign ah_new = eh_wrap[16] ? -eh_wrap : eh_wrap;

    // Shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [47:0]               gsel;
    logic signed [32:0]        err_k;

    assign err_k = err_reg[cmd.axis];
    assign gsel  = gains_reg[cmd.axis];

    always_comb
    begin
        case (cmd.a_sel)
            MA_ABS_EX: mul_a = {18'b0, abs_reg[0]};
            MA_ABS_EY: mul_a = {18'b0, abs_reg[1]};
            MA_SD:     mul_a = {18'b0, stop_dist_reg};
            MA_ERR:    mul_a = {{16{err_k[32]}}, err_k};
            MA_AREG:   mul_a = {a_reg[47], a_reg};
            MA_DREG:   mul_a = {d_reg[47], d_reg};
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            MB_LO:   mul_b = {6'b0, mul_a[14:0]};
            MB_HI:   mul_b = {5'b0, mul_a[30:15]};
            MB_DT:   mul_b = {1'b0, dt_reg};
            MB_GP:   mul_b = {{5{gsel[47]}}, gsel[47:32]};
            MB_GI:   mul_b = {{5{gsel[31]}}, gsel[31:16]};
            MB_GD:   mul_b = {{5{gsel[15]}}, gsel[15:0]};
            default: mul_b = '0;
        endcase
    end

    // Floor shifts of the product to Q16.16
    logic                     is_head;
    logic signed [PROD_W-1:0] prod_fs;
    logic signed [PROD_W-1:0] prod_fsi;

    assign is_head  = cmd.axis == AXIS_H;
    assign prod_fs  = is_head ? (prod_reg >>> FS_HEAD) : (prod_reg >>> FS_POS);
    assign prod_fsi = is_head ? (prod_reg >>> (FS_HEAD + TIME_FRAC_BITS))
                              : (prod_reg >>> (FS_POS + TIME_FRAC_BITS));

    // Integral update with saturation to 48 bits
    logic signed [55:0] acc_sum;
    logic signed [47:0] acc_sat;

    assign acc_sum = {{8{accum_reg[cmd.axis][47]}}, accum_reg[cmd.axis]} + prod_reg[55:0];

    always_comb
    begin
        if (acc_sum[55:47] == '0 || acc_sum[55:47] == '1)
            acc_sat = acc_sum[47:0];
        else if (acc_sum[55])
            acc_sat = {1'b1, 47'b0};
        else
            acc_sat = {1'b0, {47{1'b1}}};
    end

    // Derivative: magnitude division, sign applied afterward
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic [DIV_W-1:0]   quotient;
    logic               div_busy;
    logic signed [47:0] d_sat;

    assign diff     = {err_k[32], err_k} - {last_reg[cmd.axis][32], last_reg[cmd.axis]};
    assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);

    pppc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({diff_mag, {TIME_FRAC_BITS{1'b0}}}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        if (quotient[DIV_W-1:47] != '0)
            d_sat = d_neg_reg ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        else
            d_sat = d_neg_reg ? -$signed(quotient[47:0]) : $signed(quotient[47:0]);
    end

    // Final output: negate heading, saturate to 32 bits
    logic signed [63:0] v_full;
    logic signed [31:0] v_sat;

    assign v_full = is_head ? -sum_reg : sum_reg;

    always_comb
    begin
        if (v_full[63:31] == '0 || v_full[63:31] == '1)
            v_sat = v_full[31:0];
        else if (v_full[63])
            v_sat = {1'b1, 31'b0};
        else
            v_sat = {1'b0, {31{1'b1}}};
    end

    // Stop test
    logic inside_now;

    assign inside_now = pos_ok_reg && (sq_reg < lim_reg) && (ah_reg < stop_ang_reg);
    assign status.in_window = inside_now;
    assign status.div_done  = !div_busy;

    // Configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg[0]  <= GAINS_XY_RST;
            gains_reg[1]  <= GAINS_XY_RST;
            gains_reg[2]  <= GAINS_HEAD_RST;
            stop_dist_reg <= STOP_DIST_RST;
            stop_ang_reg  <= STOP_ANG_RST;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            target_h_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i]  <= '0;
                accum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAINS_X:       gains_reg[0]  <= cfg_data;
                    CFG_GAINS_Y:       gains_reg[1]  <= cfg_data;
                    CFG_GAINS_HEADING: gains_reg[2]  <= cfg_data;
                    CFG_STOP_DISTANCE: stop_dist_reg <= cfg_data[30:0];
                    CFG_STOP_ANGLE:    stop_ang_reg  <= cfg_data[14:0];
                    default:           ;
                endcase
            end
            if (cmd.load && !command)
            begin
                target_x_reg <= pose_x;
                target_y_reg <= pose_y;
                target_h_reg <= pose_heading;
            end
            if (cmd.op == AO_COMMIT)
            begin
                accum_reg[cmd.axis] <= a_reg;
                last_reg[cmd.axis]  <= err_k;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            err_reg[0] <= ex_new;
            err_reg[1] <= ey_new;
            err_reg[2] <= {{16{eh_wrap[16]}}, eh_wrap};
            abs_reg[0] <= abs_ex[30:0];
            abs_reg[1] <= abs_ey[30:0];
            pos_ok_reg <= (abs_ex[32:31] == 2'b00) && (abs_ey[32:31] == 2'b00);
            ah_reg     <= ah_new[14:0];
            dt_reg     <= elapsed_time;
        end
        if (cmd.div_start)
        begin
            d_neg_reg <= diff[33];
        end
        case (cmd.op)
            AO_SQ_SET:     sq_reg  <= prod_reg[63:0];
            AO_SQ_ADD:     sq_reg  <= sq_reg + prod_reg[63:0];
            AO_SQ_ADD_SH:  sq_reg  <= sq_reg + {prod_reg[48:0], 15'b0};
            AO_LIM_SET:    lim_reg <= prod_reg[63:0];
            AO_LIM_ADD_SH: lim_reg <= lim_reg + {prod_reg[48:0], 15'b0};
            AO_DECIDE:     inside_reg <= inside_now;
            AO_ACC_UPD:    a_reg   <= acc_sat;
            AO_SUM_P:      sum_reg <= prod_fs[63:0];
            AO_SUM_I:      sum_reg <= sum_reg + prod_fsi[63:0];
            AO_D_LOAD:     d_reg   <= d_sat;
            AO_SUM_D:      sum_reg <= sum_reg + prod_fs[63:0];
            AO_COMMIT:     res_reg[cmd.axis] <= v_sat;
            default:       ;
        endcase
        // Output register
        if (cmd.emit)
        begin
            vel_x_reg    <= inside_reg ? '0 : res_reg[0];
            vel_y_reg    <= inside_reg ? '0 : res_reg[1];
            vel_turn_reg <= inside_reg ? '0 : res_reg[2];
            stopped_reg  <= inside_reg;
        end
    end

    assign vel_x    = vel_x_reg;
    assign vel_y    = vel_y_reg;
    assign vel_turn = vel_turn_reg;
    assign stopped  = stopped_reg;

endmodule

/* src/pppc_ctrl.sv */
module pppc_ctrl
    import pppc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_command,
    input  logic       in_dt_zero,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic [3:0] step_reg;
    logic [1:0] axis_reg;
    logic       out_valid_reg;
    logic       emit_ok;

    assign emit_ok = !out_valid_reg || out_ready;

    // Step program: stop test in steps 0-7, one PID axis in steps 8-15
    always_comb
    begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.a_sel     = MA_ERR;
        cmd.b_sel     = MB_DT;
        cmd.op        = AO_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_RUN:
            begin
                case (step_reg)
                    4'd0:  begin cmd.a_sel = MA_ABS_EX; cmd.b_sel = MB_LO; end
                    4'd1:
                    begin
                        cmd.a_sel = MA_ABS_EX; cmd.b_sel = MB_HI; cmd.op = AO_SQ_SET;
                    end
                    4'd2:
                    begin
                        cmd.a_sel = MA_ABS_EY; cmd.b_sel = MB_LO; cmd.op = AO_SQ_ADD_SH;
                    end
                    4'd3:
                    begin
                        cmd.a_sel = MA_ABS_EY; cmd.b_sel = MB_HI; cmd.op = AO_SQ_ADD;
                    end
                    4'd4:
                    begin
                        cmd.a_sel = MA_SD; cmd.b_sel = MB_LO; cmd.op = AO_SQ_ADD_SH;
                    end
                    4'd5:
                    begin
                        cmd.a_sel = MA_SD; cmd.b_sel = MB_HI; cmd.op = AO_LIM_SET;
                    end
                    4'd6:  cmd.op = AO_LIM_ADD_SH;
                    4'd7:  cmd.op = AO_DECIDE;
                    4'd8:  begin cmd.a_sel = MA_ERR; cmd.b_sel = MB_DT; end
                    4'd9:
                    begin
                        cmd.op = AO_ACC_UPD; cmd.div_start = 1'b1;
                        cmd.a_sel = MA_ERR; cmd.b_sel = MB_GP;
                    end
                    4'd10:
                    begin
                        cmd.op = AO_SUM_P; cmd.a_sel = MA_AREG; cmd.b_sel = MB_GI;
                    end
                    4'd11: cmd.op = AO_SUM_I;
                    4'd12: cmd.op = status.div_done ? AO_D_LOAD : AO_NONE;
                    4'd13: begin cmd.a_sel = MA_DREG; cmd.b_sel = MB_GD; end
                    4'd14: cmd.op = AO_SUM_D;
                    4'd15: cmd.op = AO_COMMIT;
                    default: cmd.op = AO_NONE;
                endcase
            end
            S_EMIT:
            begin
                cmd.emit = emit_ok;
            end
            default: cmd = '0;
        endcase
    end

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_command && !in_dt_zero)
                    begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                        axis_reg  <= AXIS_X;
                    end
                end
                S_RUN:
                begin
                    if (step_reg == 4'd7)
                    begin
                        if (status.in_window)
                            state_reg <= S_EMIT;
                        else
                            step_reg <= 4'd8;
                    end
                    else if (step_reg == 4'd12)
                    begin
                        if (status.div_done)
                            step_reg <= 4'd13;
                    end
                    else if (step_reg == 4'd15)
                    begin
                        if (axis_reg == AXIS_H)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                            step_reg <= 4'd8;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

/* src/pppc_checker.sv */
module pppc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pose_valid,
    input logic        pose_ready,
    input logic        command,
    input logic [19:0] elapsed_time,
    input logic        drive_valid,
    input logic        drive_ready,
    input logic [31:0] vel_x,
    input logic [31:0] vel_y,
    input logic [31:0] vel_turn,
    input logic        stopped
);

    // A result waits until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && !drive_ready |=> drive_valid)
        else $error("result dropped before taken");

    // A stopped result carries zero velocities
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && stopped |-> vel_x == '0 && vel_y == '0 && vel_turn == '0)
        else $error("stopped result with nonzero velocity");

    // Target requests and zero-time measurements give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && pose_ready && (!command || elapsed_time == '0) && !drive_valid
        |=> !drive_valid)
        else $error("result from request that gives none");

    // A measurement occupies the block for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && pose_ready && command && elapsed_time != '0 |=> !pose_ready)
        else $error("request taken while measurement in work");

    // A target request leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && pose_ready && !command |=> pose_ready)
        else $error("not ready after target request");

endmodule

bind planar_pose_pid_controller pppc_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pose_valid   (pose.valid),
    .pose_ready   (pose.ready),
    .command      (pose.command),
    .elapsed_time (pose.elapsed_time),
    .drive_valid  (drive.valid),
    .drive_ready  (drive.ready),
    .vel_x        (drive.vel_x),
    .vel_y        (drive.vel_y),
    .vel_turn     (drive.vel_turn),
    .stopped      (drive.stopped)
);

/* bench/pppc_bench_pkg.sv */
package pppc_bench_pkg;

    // One request as seen on the pose channel
    typedef struct packed {
        logic               command;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic        [19:0] elapsed_time;
    } pose_req_t;

    // One drive result
    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_turn;
        logic               stopped;
    } drive_res_t;

    localparam logic CMD_TARGET  = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

endpackage

/* bench/pppc_pid_checker.sv */
module pppc_pid_checker
    import pppc_pkg::*;
    import pppc_bench_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        pose_valid,
    input  logic        pose_ready,
    input  pose_req_t   pose_req,
    input  logic        drive_valid,
    input  logic        drive_ready,
    input  drive_res_t  drive_res,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< 47);

    // Predictor copy of registers and state
    logic [47:0] g_x, g_y, g_h;
    logic [30:0] stop_dist;
    logic [14:0] stop_ang;
    longint tgt_x, tgt_y, tgt_h;
    longint prev_ex, prev_ey, prev_eh;
    longint integ_x, integ_y, integ_h;
    drive_res_t expected_drive[$];

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Arithmetic shift on signed longint is a floor shift
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint gain_at(logic [47:0] g, int pos);
        logic signed [15:0] v;
        v = g[pos +: 16];
        return longint'(v);
    endfunction

    // One PID axis: updates integrator and last error, returns the summed terms
    function automatic longint pid_step(logic [47:0] g, longint err, ref longint last,
                                        ref longint integ, input longint dt, input int fs);
        longint a, d, p_t, i_t, d_t;
        a = sat(integ + err * dt, SAT_LO, SAT_HI);
        d = sat(((err - last) * (64'sd1 <<< TIME_FRAC_BITS)) / dt, SAT_LO, SAT_HI);
        p_t = fshr(gain_at(g, 32) * err, fs);
        i_t = fshr(gain_at(g, 16) * a, fs + TIME_FRAC_BITS);
        d_t = fshr(gain_at(g, 0) * d, fs);
        integ = a;
        last = err;
        return p_t + i_t + d_t;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        return 32'(sat(v, -64'sd2147483648, 64'sd2147483647));
    endfunction

    task automatic predict_drive(pose_req_t r);
        longint ex, ey, eh, ah, dt, vx, vy, vt;
        logic [63:0] sq, lim;
        logic in_window;
        drive_res_t res;
        dt = longint'(r.elapsed_time);
        if (r.command == CMD_TARGET)
        begin
            tgt_x = r.pose_x;
            tgt_y = r.pose_y;
            tgt_h = r.pose_heading;
            return;
        end
        if (dt == 0)
            return;
        ex = tgt_x - longint'(r.pose_x);
        ey = tgt_y - longint'(r.pose_y);
        eh = tgt_h - longint'(r.pose_heading);
        while (eh > PI_Q13) eh -= TWO_PI_Q13;
        while (eh < -PI_Q13) eh += TWO_PI_Q13;
        ah = eh < 0 ? -eh : eh;
        in_window = 1'b0;
        if (ex > -(64'sd1 <<< 31) && ex < (64'sd1 <<< 31) &&
            ey > -(64'sd1 <<< 31) && ey < (64'sd1 <<< 31))
        begin
            sq = 64'(ex * ex) + 64'(ey * ey);
            lim = 64'(stop_dist) * 64'(stop_dist);
            in_window = sq < lim && ah < longint'(stop_ang);
        end
        if (in_window)
        begin
            res = '{vel_x: '0, vel_y: '0, vel_turn: '0, stopped: 1'b1};
        end
        else
        begin
            vx = pid_step(g_x, ex, prev_ex, integ_x, dt, FS_POS);
            vy = pid_step(g_y, ey, prev_ey, integ_y, dt, FS_POS);
            vt = -pid_step(g_h, eh, prev_eh, integ_h, dt, FS_HEAD);
            res = '{vel_x: clip32(vx), vel_y: clip32(vy), vel_turn: clip32(vt),
                    stopped: 1'b0};
        end
        expected_drive.push_back(res);
    endtask

    assign pending = expected_drive.size();

    always @(posedge clk or negedge rst_n)
    begin
        drive_res_t exp_r;
        if (!rst_n)
        begin
            g_x = GAINS_XY_RST;
            g_y = GAINS_XY_RST;
            g_h = GAINS_HEAD_RST;
            stop_dist = STOP_DIST_RST;
            stop_ang = STOP_ANG_RST;
            tgt_x = 0; tgt_y = 0; tgt_h = 0;
            prev_ex = 0; prev_ey = 0; prev_eh = 0;
            integ_x = 0; integ_y = 0; integ_h = 0;
            expected_drive.delete();
            errors = 0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAINS_X:       g_x = cfg_data;
                    CFG_GAINS_Y:       g_y = cfg_data;
                    CFG_GAINS_HEADING: g_h = cfg_data;
                    CFG_STOP_DISTANCE: stop_dist = cfg_data[30:0];
                    CFG_STOP_ANGLE:    stop_ang = cfg_data[14:0];
                    default: ;
                endcase
            end
            // Compare result against oldest expectation
            if (drive_valid && drive_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected drive result %p", drive_res);
                end
                else
                begin
                    exp_r = expected_drive.pop_front();
                    if (exp_r !== drive_res)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("drive mismatch: expected %p got %p", exp_r, drive_res);
                    end
                end
            end
            if (pose_valid && pose_ready)
                predict_drive(pose_req);
        end
    end

endmodule

/* bench/planar_pose_pid_controller_tb.sv */
module planar_pose_pid_controller_tb;
    import pppc_pkg::*;
    import pppc_bench_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          errors;
    int          pending;
    logic [31:0] cur_tx, cur_ty;
    logic [15:0] cur_th;

    pppc_pose_if  pose ();
    pppc_drive_if drive ();

    planar_pose_pid_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose.sink),
        .drive     (drive.source)
    );

    pppc_pid_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pose_valid  (pose.valid),
        .pose_ready  (pose.ready),
        .pose_req    ({pose.command, pose.pose_x, pose.pose_y, pose.pose_heading,
                       pose.elapsed_time}),
        .drive_valid (drive.valid),
        .drive_ready (drive.ready),
        .drive_res   ({drive.vel_x, drive.vel_y, drive.vel_turn, drive.stopped}),
        .errors      (errors),
        .pending     (pending)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard limit
    initial
    begin
        #80ms;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls per result
    initial
    begin
        int w;
        drive.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) w = 0;
            repeat (w) @(negedge clk);
            @(negedge clk);
            drive.ready <= 1'b1;
            do @(posedge clk); while (!drive.valid);
            @(negedge clk);
            drive.ready <= 1'b0;
        end
    end

    // Valid stays high into the next request when there is no gap
    task automatic send_pose(logic cmd, logic [31:0] x, logic [31:0] y, logic [15:0] h,
                             logic [19:0] dt, bit no_gap = 0);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 17);
        if (w > 0)
        begin
            pose.valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        pose.valid        <= 1'b1;
        pose.command      <= cmd;
        pose.pose_x       <= x;
        pose.pose_y       <= y;
        pose.pose_heading <= h;
        pose.elapsed_time <= dt;
        do @(posedge clk); while (!pose.ready);
        @(negedge clk);
        if (cmd == CMD_TARGET)
        begin
            cur_tx = x; cur_ty = y; cur_th = h;
        end
    endtask

    function automatic logic [15:0] rand_heading();
        return 16'($signed($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
    endfunction

    // Offset from the target: sometimes none, small or large, sometimes fully random
    function automatic logic [31:0] near(logic [31:0] t);
        case ($urandom_range(0, 3))
            0: return t;
            1: return t + 32'($signed($urandom_range(0, 600)) - 300);
            2: return t + 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    // Stop sending and wait until all results are in
    task automatic drain();
        pose.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [31:0] x, y;
        logic [15:0] h;
        logic [19:0] dt;
        for (int i = 0; i < n; i++)
        begin
            dt = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 40000));
            if ($urandom_range(0, 40) == 0) dt = 0;
            case ($urandom_range(0, 9))
                0: send_pose(CMD_TARGET, $urandom, $urandom, rand_heading(), 20'($urandom));
                1: send_pose(CMD_TARGET, 32'($urandom_range(0, 400000)) - 200000,
                             32'($urandom_range(0, 400000)) - 200000, rand_heading(),
                             20'($urandom), $urandom_range(0, 2) == 0);
                default:
                begin
                    x = near(cur_tx);
                    y = near(cur_ty);
                    h = ($urandom_range(0, 1) == 0)
                        ? 16'(cur_th + 16'($urandom_range(0, 80)) - 16'd40)
                        : rand_heading();
                    send_pose(CMD_MEASURE, x, y, h, dt, $urandom_range(0, 4) == 0);
                end
            endcase
        end
    endtask

    // Stimulus
    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pose.valid = 1'b0;
        pose.command = CMD_TARGET;
        pose.pose_x = '0;
        pose.pose_y = '0;
        pose.pose_heading = '0;
        pose.elapsed_time = '0;
        cur_tx = '0; cur_ty = '0; cur_th = '0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, wrap, zero time, stop window
        send_pose(CMD_MEASURE, 32'h0, 32'h0, 16'h0, 20'd1000);
        send_pose(CMD_MEASURE, 32'd100, 32'd0, 16'd0, 20'd0);
        send_pose(CMD_MEASURE, 32'h7FFF_FFFF, 32'h8000_0000, 16'($signed(PI_Q13)), 20'hFFFFF);
        send_pose(CMD_MEASURE, 32'h8000_0000, 32'h7FFF_FFFF, 16'(-PI_Q13), 20'd1);
        send_pose(CMD_TARGET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'($signed(PI_Q13)), 20'hFFFFF);
        send_pose(CMD_MEASURE, 32'h8000_0000, 32'h8000_0000, 16'(-PI_Q13), 20'd1);
        send_pose(CMD_MEASURE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'(-PI_Q13 + 10), 20'd3);
        send_pose(CMD_TARGET, 32'h8000_0000, 32'h0, 16'(-PI_Q13), 20'd0);
        send_pose(CMD_MEASURE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'($signed(PI_Q13)), 20'd7);
        send_pose(CMD_TARGET, 32'd5000, 32'd5000, 16'd100, 20'd0);
        send_pose(CMD_MEASURE, 32'd5100, 32'd5100, 16'd120, 20'd500);
        send_pose(CMD_MEASURE, 32'd5231, 32'd5000, 16'd100, 20'd500);
        send_pose(CMD_MEASURE, 32'd5000, 32'd5000, 16'd141, 20'd500);
        send_pose(CMD_MEASURE, 32'd5000, 32'd5000, 16'd100, 20'hFFFFF);
        send_pose(CMD_MEASURE, 32'hFFFF_0000, 32'h0001_0000, 16'hFFFF, 20'h80000);
        drain();

        // Extreme register settings
        write_reg(CFG_GAINS_X, 48'h7FFF_7FFF_7FFF);
        write_reg(CFG_GAINS_Y, 48'h8000_8000_8000);
        write_reg(CFG_GAINS_HEADING, 48'h7FFF_8000_7FFF);
        write_reg(CFG_STOP_DISTANCE, 48'h7FFF_FFFF);
        write_reg(CFG_STOP_ANGLE, 48'd25736);
        random_phase(150);
        drain();
        write_reg(CFG_STOP_DISTANCE, 48'd0);
        write_reg(CFG_STOP_ANGLE, 48'd0);
        random_phase(150);
        drain();

        // Random settings per phase
        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_GAINS_X, {rand_gain(), rand_gain(), rand_gain()});
            write_reg(CFG_GAINS_Y, {rand_gain(), rand_gain(), rand_gain()});
            write_reg(CFG_GAINS_HEADING, {rand_gain(), rand_gain(), rand_gain()});
            write_reg(CFG_STOP_DISTANCE, ($urandom_range(0, 3) == 0) ? 48'($urandom >> 1)
                                         : 48'($urandom_range(0, 2000)));
            write_reg(CFG_STOP_ANGLE, 48'($urandom_range(0, 25736)));
            random_phase(150);
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
